>>> hw/rtl/bhq_pkg.sv
// Shared types and codes for the binary min-heap queue.
`default_nettype none
package bhq_pkg;

   localparam int VALUE_W = 32;
   localparam int FILL_W  = 9;

   localparam logic [1:0] KIND_INSERT  = 2'd0;
   localparam logic [1:0] KIND_EXTRACT = 2'd1;
   localparam logic [1:0] KIND_DELETE  = 2'd2;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_EMPTY     = 2'd1;
   localparam logic [1:0] STAT_FULL      = 2'd2;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

   localparam logic signed [VALUE_W-1:0] VALUE_MINUS_ONE = '1;
   localparam logic signed [VALUE_W-1:0] VALUE_MOST_NEG  = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic signed [VALUE_W-1:0] VALUE_ZERO      = '0;

   typedef struct packed {
      logic [1:0]                kind;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]                status;
      logic signed [VALUE_W-1:0] out_value;
      logic [FILL_W-1:0]         fill_count;
   } rsp_type;

endpackage
`default_nettype wire

>>> hw/rtl/bhq_mem.sv
// Heap entry store: one write port, one read port with registered data.
`default_nettype none
module bhq_mem
   import bhq_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [$clog2(CAPACITY)-1:0] wr_addr,
   input  wire logic signed [VALUE_W-1:0] wr_data,
   input  wire logic [$clog2(CAPACITY)-1:0] rd_addr,
   output logic signed [VALUE_W-1:0]      rd_data
);

   logic signed [VALUE_W-1:0] heap_mem [CAPACITY];
   logic signed [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= heap_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> hw/rtl/bhq_ctrl.sv
// Heap sequencer: sift up, sift down and delete scan over the entry store.
`default_nettype none
module bhq_ctrl
   import bhq_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire req_type                     req_word,
   output logic                             req_stall,
   output logic                             done,
   output rsp_type                          done_word,
   input  wire logic                        slot_free,
   output logic                             mem_wr_en,
   output logic [$clog2(CAPACITY)-1:0]      mem_wr_addr,
   output logic signed [VALUE_W-1:0]        mem_wr_data,
   output logic [$clog2(CAPACITY)-1:0]      mem_rd_addr,
   input  wire logic signed [VALUE_W-1:0]   mem_rd_data
);

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int IDX_W  = ADDR_W + 1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_EX_RD_ROOT,
      ST_EX_RD_LAST,
      ST_EX_LOAD,
      ST_DN_RD_L,
      ST_DN_RD_R,
      ST_DN_CMP,
      ST_SCAN,
      ST_FIN
   } state_type;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [ADDR_W-1:0]         pos_ff, pos_in;
   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic signed [VALUE_W-1:0] ldat_ff, ldat_in;
   logic [1:0]                op_ff, op_in;
   logic [CNT_W-1:0]          idx_ff, idx_in;
   logic                      chk_vld_ff, chk_vld_in;
   logic [ADDR_W-1:0]         chk_idx_ff, chk_idx_in;
   logic [1:0]                stat_ff, stat_in;
   logic signed [VALUE_W-1:0] outv_ff, outv_in;

   logic [ADDR_W-1:0]         parent;
   logic [IDX_W-1:0]          lch, rch, cnt_ext;
   logic                      l_ok, r_ok, go_l, go_r;
   logic signed [VALUE_W-1:0] best_v;

   assign parent  = ADDR_W'((pos_ff - ADDR_W'(1)) >> 1);
   assign lch     = {pos_ff, 1'b1};
   assign rch     = lch + IDX_W'(1);
   assign cnt_ext = IDX_W'(count_ff);
   assign l_ok    = lch < cnt_ext;
   assign r_ok    = rch < cnt_ext;
   assign go_l    = ldat_ff < val_ff;
   assign best_v  = go_l ? ldat_ff : val_ff;
   assign go_r    = r_ok && (mem_rd_data < best_v);

   assign req_stall            = (state_ff != ST_IDLE);
   assign done                 = (state_ff == ST_FIN);
   assign done_word.status     = stat_ff;
   assign done_word.out_value  = outv_ff;
   assign done_word.fill_count = FILL_W'(count_ff);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      pos_in      = pos_ff;
      val_in      = val_ff;
      ldat_in     = ldat_ff;
      op_in       = op_ff;
      idx_in      = idx_ff;
      chk_vld_in  = chk_vld_ff;
      chk_idx_in  = chk_idx_ff;
      stat_in     = stat_ff;
      outv_in     = outv_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = pos_ff;
      mem_wr_data = val_ff;
      mem_rd_addr = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in   = req_word.kind;
               val_in  = req_word.value;
               stat_in = STAT_OK;
               outv_in = VALUE_ZERO;
               case (req_word.kind)
                  KIND_INSERT: begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        stat_in  = STAT_FULL;
                        state_in = ST_FIN;
                     end else begin
                        pos_in   = ADDR_W'(count_ff);
                        count_in = count_ff + CNT_W'(1);
                        state_in = ST_UP_RD;
                     end
                  end
                  KIND_EXTRACT: begin
                     if (count_ff == '0) begin
                        stat_in  = STAT_EMPTY;
                        outv_in  = VALUE_MINUS_ONE;
                        state_in = ST_FIN;
                     end else begin
                        state_in = ST_EX_RD_ROOT;
                     end
                  end
                  KIND_DELETE: begin
                     stat_in    = STAT_NOT_FOUND;
                     idx_in     = '0;
                     chk_vld_in = 1'b0;
                     state_in   = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_FIN;
                  end
               endcase
            end
         end

         // hole walks up; parents move down into it
         ST_UP_RD: begin
            if (pos_ff == '0) begin
               mem_wr_en = 1'b1;
               state_in  = (op_ff == KIND_DELETE) ? ST_EX_RD_ROOT : ST_FIN;
            end else begin
               mem_rd_addr = parent;
               state_in    = ST_UP_CMP;
            end
         end

         ST_UP_CMP: begin
            mem_wr_en = 1'b1;
            if (val_ff < mem_rd_data) begin
               mem_wr_data = mem_rd_data;
               pos_in      = parent;
               state_in    = ST_UP_RD;
            end else begin
               state_in = (op_ff == KIND_DELETE) ? ST_EX_RD_ROOT : ST_FIN;
            end
         end

         ST_EX_RD_ROOT: begin
            mem_rd_addr = '0;
            state_in    = ST_EX_RD_LAST;
         end

         ST_EX_RD_LAST: begin
            mem_rd_addr = ADDR_W'(count_ff - CNT_W'(1));
            count_in    = count_ff - CNT_W'(1);
            if (op_ff == KIND_EXTRACT) begin
               outv_in = mem_rd_data;
            end
            state_in = ST_EX_LOAD;
         end

         ST_EX_LOAD: begin
            val_in   = mem_rd_data;
            pos_in   = '0;
            state_in = (count_ff == '0) ? ST_FIN : ST_DN_RD_L;
         end

         // hole walks down from the root; smaller child moves up
         ST_DN_RD_L: begin
            if (!l_ok) begin
               mem_wr_en = 1'b1;
               state_in  = ST_FIN;
            end else begin
               mem_rd_addr = lch[ADDR_W-1:0];
               state_in    = ST_DN_RD_R;
            end
         end

         ST_DN_RD_R: begin
            ldat_in = mem_rd_data;
            if (r_ok) begin
               mem_rd_addr = rch[ADDR_W-1:0];
            end
            state_in = ST_DN_CMP;
         end

         ST_DN_CMP: begin
            mem_wr_en = 1'b1;
            if (go_r) begin
               mem_wr_data = mem_rd_data;
               pos_in      = rch[ADDR_W-1:0];
               state_in    = ST_DN_RD_L;
            end else if (go_l) begin
               mem_wr_data = ldat_ff;
               pos_in      = lch[ADDR_W-1:0];
               state_in    = ST_DN_RD_L;
            end else begin
               state_in = ST_FIN;
            end
         end

         // one read issued per cycle, compare uses the registered read data
         ST_SCAN: begin
            mem_rd_addr = ADDR_W'(idx_ff);
            chk_vld_in  = idx_ff < count_ff;
            chk_idx_in  = ADDR_W'(idx_ff);
            if (idx_ff < count_ff) begin
               idx_in = idx_ff + CNT_W'(1);
            end
            if (chk_vld_ff && (mem_rd_data == val_ff)) begin
               stat_in  = STAT_OK;
               pos_in   = chk_idx_ff;
               val_in   = VALUE_MOST_NEG;
               state_in = ST_UP_RD;
            end else if (idx_ff >= count_ff) begin
               state_in = ST_FIN;
            end
         end

         ST_FIN: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         chk_vld_ff <= chk_vld_in;
      end
      pos_ff     <= pos_in;
      val_ff     <= val_in;
      ldat_ff    <= ldat_in;
      op_ff      <= op_in;
      idx_ff     <= idx_in;
      chk_idx_ff <= chk_idx_in;
      stat_ff    <= stat_in;
      outv_ff    <= outv_in;
   end

endmodule
`default_nettype wire

>>> hw/rtl/binary_min_heap_queue.sv
// Top level of the binary min-heap queue with its result register.
`default_nettype none
// Min-heap of signed 32-bit words held in one single-port-write, one-port-read
// memory of CAPACITY entries. A request word inserts, extracts the minimum or
// deletes the first entry equal to a value; each gives exactly one result word
// with a status and the fill count. Requests are handled one at a time, each
// step of a sift being a memory read followed by a compare and write back.
// An insert opens a hole at the end of the heap and sifts the new word up; an
// extract reads the root and the last word, then sifts that word down from the
// root, unless the heap is then empty; delete scans one entry per cycle, forces
// the match to the most negative value, sifts it up to the root, then runs the
// extract sequence, and on a miss reports not found. Full, empty and unused
// requests go straight to the result. A finished result sits in an output
// register, so the next request is taken in the cycle after it is loaded while
// it waits; a second finished request holds in its final state until that
// register frees up.
module binary_min_heap_queue
   import bhq_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire req_type req_word,
   output logic         req_stall,
   output logic         rsp_valid,
   output rsp_type      rsp_word,
   input  wire logic    rsp_stall
);

   localparam int ADDR_W = $clog2(CAPACITY);

   logic                      done;
   rsp_type                   done_word;
   logic                      slot_free;
   logic                      mem_wr_en;
   logic [ADDR_W-1:0]         mem_wr_addr;
   logic signed [VALUE_W-1:0] mem_wr_data;
   logic [ADDR_W-1:0]         mem_rd_addr;
   logic signed [VALUE_W-1:0] mem_rd_data;

   logic    rsp_vld_ff, rsp_vld_in;
   rsp_type rsp_word_ff, rsp_word_in;

   bhq_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_word    (req_word),
      .req_stall   (req_stall),
      .done        (done),
      .done_word   (done_word),
      .slot_free   (slot_free),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   bhq_mem #(.CAPACITY(CAPACITY)) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign slot_free = !rsp_vld_ff || !rsp_stall;

   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_word_in = rsp_word_ff;
      if (done && slot_free) begin
         rsp_vld_in  = 1'b1;
         rsp_word_in = done_word;
      end else if (!rsp_stall) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
`default_nettype wire
